FILE: src/phe_pkg.sv
// Package for the point history extrapolator: beat types, mode and sequencer codes.
// No dependencies.
`default_nettype none
package phe_pkg;
    localparam int TW          = 32;
    localparam int VALUE_WIDTH = 32;

    typedef struct packed {
        logic                 op;
        logic signed [TW-1:0] sample_time;
        logic signed [TW-1:0] sample_value;
    } in_beat_t;

    typedef struct packed {
        logic signed [TW-1:0] predicted_value;
        logic                 can_guess;
    } out_beat_t;

    localparam logic OP_PUSH    = 1'b0;
    localparam logic OP_PREDICT = 1'b1;

    localparam logic [0:0] REG_ENABLE = 1'b0;
    localparam logic [0:0] REG_MODE   = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DT0, S_DV0, S_SPD, S_SPDW, S_CUR, S_MUL1, S_RES1,
        S_DT1, S_DV1, S_PRV, S_PRVW, S_DACC, S_ACC, S_ACCW,
        S_MUL2, S_MUL3, S_HALF, S_RES2,
        S_FIN, S_OUT
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;
endpackage
`default_nettype wire

FILE: src/point_history_extrapolator_unit.sv
// Top level of the point history extrapolator: history store, sequencer, shared ALU.
// Depends on phe_pkg and phe_div.
//
//  channel | direction | handshake          | payload
//  in      | into      | in_valid/in_ready  | phe_pkg::in_beat_t
//  out     | out of    | out_valid/out_ready| phe_pkg::out_beat_t
//  cfg     | into      | cfg_we             | cfg_index, cfg_data
//
// A beat that needs no extrapolation goes straight to the finish step; a linear
// extrapolation runs one division and a quadratic one three, all in the shared
// divider, which skips its bit iterations when the divisor is zero.
// One beat is in flight; in_ready is low until its result is in the output
// register, and the finish step waits while an earlier result is unaccepted.
// Reset clears the history count.
`default_nettype none
module point_history_extrapolator_unit #(
    parameter int FRAC_BITS   = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire phe_pkg::in_beat_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output phe_pkg::out_beat_t  out_data,
    input  wire                 cfg_we,
    input  wire [0:0]           cfg_index,
    input  wire [1:0]           cfg_data
);
    localparam int W  = phe_pkg::VALUE_WIDTH;
    localparam int TW = phe_pkg::TW;
    localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] T32MAX = W'(64'sh7FFF_FFFF);
    localparam logic signed [W-1:0] T32MIN = W'(-64'sh8000_0000);

    phe_pkg::state_t state_reg, state_next;

    logic                 enable_reg;
    logic [1:0]           mode_reg;
    logic [1:0]           cnt_reg, cnt_next;
    logic signed [TW-1:0] ht_reg [3];
    logic signed [TW-1:0] hv_reg [3];
    logic                 op_reg;
    logic signed [TW-1:0] t_reg, v_reg;
    logic signed [W-1:0]  dt0_reg, spd_reg, cur_reg, acc_reg, tmp_reg, res_reg;
    logic signed [W-1:0]  a_reg;
    phe_pkg::out_beat_t   out_reg;
    logic                 out_valid_reg;

    logic [1:0] cap;
    logic       full;
    assign cap  = mode_reg[0] ? 2'd3 : 2'd2;
    assign full = cnt_reg >= cap;

    // shared ALU
    phe_pkg::alu_op_t     alu_op;
    logic signed [W-1:0]  alu_a, alu_b, alu_y;
    logic signed [W:0]    sum;
    logic [W-1:0]         mga, mgb;
    logic [2*W-1:0]       prod;
    logic [2*W-1:0]       pq;
    logic                 pneg;

    always_comb
    begin
        mga = alu_a[W-1] ? W'(-alu_a) : W'(alu_a);
        mgb = alu_b[W-1] ? W'(-alu_b) : W'(alu_b);
        prod = mga * mgb;
        pq = prod >> FRAC_BITS;
        pneg = alu_a[W-1] ^ alu_b[W-1];
        sum = '0;
        alu_y = '0;
        case (alu_op)
            phe_pkg::ALU_ADD, phe_pkg::ALU_SUB:
            begin
                sum = (alu_op == phe_pkg::ALU_ADD) ? ({alu_a[W-1], alu_a} + {alu_b[W-1], alu_b})
                                                   : ({alu_a[W-1], alu_a} - {alu_b[W-1], alu_b});
                if (sum[W] != sum[W-1])
                    alu_y = sum[W] ? VMIN : VMAX;
                else
                    alu_y = sum[W-1:0];
            end
            phe_pkg::ALU_MUL:
            begin
                if (pneg)
                    alu_y = (pq > (2*W)'(VMAX) + 1) ? VMIN : W'(-pq);
                else
                    alu_y = (pq > (2*W)'(VMAX)) ? VMAX : W'(pq);
            end
            default: alu_y = '0;
        endcase
    end

    // divider
    logic                div_start, div_done;
    logic signed [W-1:0] div_q;

    phe_div #(.VALUE_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tmp_reg),
        .divisor  (dt0_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    function automatic logic signed [W-1:0] ext(input logic signed [TW-1:0] x);
        return W'(x);
    endfunction

    function automatic logic signed [TW-1:0] clip32(input logic signed [W-1:0] x);
        if (x > T32MAX)
            return TW'(T32MAX);
        else if (x < T32MIN)
            return TW'(T32MIN);
        return TW'(x);
    endfunction

    // Operand selection per step
    always_comb
    begin
        alu_op = phe_pkg::ALU_SUB;
        alu_a = '0;
        alu_b = '0;
        case (state_reg)
            phe_pkg::S_DT0:  begin alu_a = ext(ht_reg[0]); alu_b = ext(ht_reg[1]); end
            phe_pkg::S_DV0:  begin alu_a = ext(hv_reg[0]); alu_b = ext(hv_reg[1]); end
            phe_pkg::S_CUR:  begin alu_a = ext(t_reg); alu_b = ext(ht_reg[0]); end
            phe_pkg::S_MUL1: begin alu_op = phe_pkg::ALU_MUL; alu_a = spd_reg; alu_b = cur_reg; end
            phe_pkg::S_RES1: begin alu_op = phe_pkg::ALU_ADD; alu_a = tmp_reg; alu_b = ext(hv_reg[0]); end
            phe_pkg::S_DT1:  begin alu_a = ext(ht_reg[1]); alu_b = ext(ht_reg[2]); end
            phe_pkg::S_DV1:  begin alu_a = ext(hv_reg[1]); alu_b = ext(hv_reg[2]); end
            phe_pkg::S_DACC: begin alu_a = spd_reg; alu_b = tmp_reg; end
            phe_pkg::S_MUL2: begin alu_op = phe_pkg::ALU_MUL; alu_a = acc_reg; alu_b = cur_reg; end
            phe_pkg::S_MUL3: begin alu_op = phe_pkg::ALU_MUL; alu_a = tmp_reg; alu_b = cur_reg; end
            phe_pkg::S_RES2: begin alu_op = phe_pkg::ALU_ADD; alu_a = res_reg; alu_b = tmp_reg; end
            default: ;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            phe_pkg::S_IDLE:
                if (in_valid && in_ready) begin
                    if (!enable_reg)
                        state_next = phe_pkg::S_FIN;
                    else if (in_data.op == phe_pkg::OP_PREDICT)
                        state_next = full ? phe_pkg::S_DT0 : phe_pkg::S_FIN;
                    else if (cnt_reg != 2'd0 && mode_reg[1] && full)
                        state_next = phe_pkg::S_DT0;
                    else
                        state_next = phe_pkg::S_FIN;
                end
            phe_pkg::S_DT0:  state_next = phe_pkg::S_DV0;
            phe_pkg::S_DV0:  state_next = phe_pkg::S_SPD;
            phe_pkg::S_SPD:  state_next = phe_pkg::S_SPDW;
            phe_pkg::S_SPDW: if (div_done) state_next = phe_pkg::S_CUR;
            phe_pkg::S_CUR:  state_next = phe_pkg::S_MUL1;
            phe_pkg::S_MUL1: state_next = phe_pkg::S_RES1;
            phe_pkg::S_RES1: state_next = mode_reg[0] ? phe_pkg::S_DT1 : phe_pkg::S_FIN;
            phe_pkg::S_DT1:  state_next = phe_pkg::S_DV1;
            phe_pkg::S_DV1:  state_next = phe_pkg::S_PRV;
            phe_pkg::S_PRV:  state_next = phe_pkg::S_PRVW;
            phe_pkg::S_PRVW: if (div_done) state_next = phe_pkg::S_DACC;
            phe_pkg::S_DACC: state_next = phe_pkg::S_ACC;
            phe_pkg::S_ACC:  state_next = phe_pkg::S_ACCW;
            phe_pkg::S_ACCW: if (div_done) state_next = phe_pkg::S_MUL2;
            phe_pkg::S_MUL2: state_next = phe_pkg::S_MUL3;
            phe_pkg::S_MUL3: state_next = phe_pkg::S_HALF;
            phe_pkg::S_HALF: state_next = phe_pkg::S_RES2;
            phe_pkg::S_RES2: state_next = phe_pkg::S_FIN;
            phe_pkg::S_FIN:  if (!out_valid_reg || out_ready) state_next = phe_pkg::S_OUT;
            phe_pkg::S_OUT:  state_next = phe_pkg::S_IDLE;
            default:         state_next = phe_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        in_ready  = (state_reg == phe_pkg::S_IDLE);
        div_start = (state_reg == phe_pkg::S_SPD) || (state_reg == phe_pkg::S_PRV)
                 || (state_reg == phe_pkg::S_ACC);
    end

    // Push bookkeeping and the result beat at the finish step
    logic signed [TW-1:0] vs;
    logic signed [TW:0]   avg;
    logic                 same_t;
    logic [1:0]           cnt_push;
    logic                 fin_go;
    phe_pkg::out_beat_t   fin_beat;

    assign fin_go = (state_reg == phe_pkg::S_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        avg = (TW+1)'(v_reg >>> 1) + (TW+1)'(clip32(res_reg) >>> 1)
            + (TW+1)'({1'b0, v_reg[0] & res_reg[0]});
        vs = (mode_reg[1] && full) ? TW'(avg) : v_reg;
        same_t = (ht_reg[0] == t_reg);
        cnt_push = cnt_reg;
        if (cnt_reg == 2'd0)
            cnt_push = 2'd1;
        else begin
            if (!same_t && cnt_reg < cap)
                cnt_push = cnt_reg + 2'd1;
            if (cnt_push > cap)
                cnt_push = cap;
        end
        cnt_next = cnt_reg;
        if (fin_go && enable_reg && op_reg == phe_pkg::OP_PUSH)
            cnt_next = cnt_push;
        fin_beat = '0;
        if (enable_reg) begin
            if (op_reg == phe_pkg::OP_PUSH)
                fin_beat.can_guess = cnt_push >= cap;
            else if (full) begin
                fin_beat.predicted_value = clip32(res_reg);
                fin_beat.can_guess = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= phe_pkg::S_IDLE;
            enable_reg    <= 1'b0;
            mode_reg      <= 2'd0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_we && cfg_index == phe_pkg::REG_ENABLE)
                enable_reg <= cfg_data[0];
            if (cfg_we && cfg_index == phe_pkg::REG_MODE)
                mode_reg <= cfg_data;
            if (fin_go)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            op_reg <= in_data.op;
            t_reg  <= in_data.sample_time;
            v_reg  <= in_data.sample_value;
        end
        case (state_reg)
            phe_pkg::S_DT0:  dt0_reg <= alu_y;
            phe_pkg::S_DV0:  tmp_reg <= alu_y;
            phe_pkg::S_SPDW: if (div_done) spd_reg <= div_q;
            phe_pkg::S_CUR:  cur_reg <= alu_y;
            phe_pkg::S_MUL1: tmp_reg <= alu_y;
            phe_pkg::S_RES1: res_reg <= alu_y;
            phe_pkg::S_DT1:  a_reg <= alu_y;
            phe_pkg::S_DV1:  begin tmp_reg <= alu_y; dt0_reg <= a_reg; a_reg <= dt0_reg; end
            phe_pkg::S_PRVW: if (div_done) begin tmp_reg <= div_q; dt0_reg <= a_reg; end
            phe_pkg::S_DACC: tmp_reg <= alu_y;
            phe_pkg::S_ACCW: if (div_done) acc_reg <= div_q;
            phe_pkg::S_MUL2: tmp_reg <= alu_y;
            phe_pkg::S_MUL3: tmp_reg <= alu_y;
            phe_pkg::S_HALF: tmp_reg <= (tmp_reg + (tmp_reg[W-1] ? W'(1) : W'(0))) >>> 1;
            phe_pkg::S_RES2: res_reg <= alu_y;
            phe_pkg::S_FIN:
            begin
                if (!out_valid_reg || out_ready) begin
                    out_reg <= fin_beat;
                    if (enable_reg && op_reg == phe_pkg::OP_PUSH) begin
                        if (cnt_reg == 2'd0 || !same_t) begin
                            ht_reg[2] <= ht_reg[1];
                            hv_reg[2] <= hv_reg[1];
                            ht_reg[1] <= ht_reg[0];
                            hv_reg[1] <= hv_reg[0];
                            ht_reg[0] <= t_reg;
                        end
                        hv_reg[0] <= (cnt_reg == 2'd0) ? v_reg : vs;
                    end
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
endmodule
`default_nettype wire

FILE: src/phe_div.sv
// Radix-2 restoring fixed-point divider, one quotient bit per cycle, saturating.
// Depends on nothing but its parameters.
`default_nettype none
module phe_div #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           start,
    input  wire signed [VALUE_WIDTH-1:0]  dividend,
    input  wire signed [VALUE_WIDTH-1:0]  divisor,
    output logic                          done,
    output logic signed [VALUE_WIDTH-1:0] quotient
);
    localparam int W  = VALUE_WIDTH;
    localparam int NW = W + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0]     num_reg, num_next;
    logic [W-1:0]      rem_reg, rem_next;
    logic [NW-1:0]     q_reg, q_next;
    logic [W-1:0]      den_reg, den_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic signed [W-1:0] res_reg, res_next;

    logic [W-1:0] ma, mb;
    logic [W:0]   shifted;
    logic [W:0]   trial;
    logic [NW-1:0] qn;
    logic [NW:0]  lim;

    always_comb
    begin
        ma = dividend[W-1] ? W'(-dividend) : W'(dividend);
        mb = divisor[W-1] ? W'(-divisor) : W'(divisor);
        shifted = {rem_reg, num_reg[NW-1]};
        trial = shifted - {1'b0, den_reg};
        qn = {q_reg[NW-2:0], ~trial[W]};
        lim = neg_reg ? (NW+1)'({1'b1, {(W-1){1'b0}}}) : (NW+1)'({1'b0, {(W-1){1'b1}}});
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next = res_reg;
        if (start) begin
            if (mb == '0) begin
                done_next = 1'b1;
                if (ma == '0)
                    res_next = '0;
                else
                    res_next = dividend[W-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
            end else begin
                busy_next = 1'b1;
                num_next = NW'(ma) << FRAC_BITS;
                rem_next = '0;
                q_next = '0;
                den_next = mb;
                neg_next = dividend[W-1] ^ divisor[W-1];
                cnt_next = CW'(NW);
            end
        end else if (busy_reg) begin
            num_next = num_reg << 1;
            rem_next = trial[W] ? shifted[W-1:0] : trial[W-1:0];
            q_next = qn;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if ({1'b0, qn} > lim)
                    res_next = neg_reg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
                else
                    res_next = neg_reg ? W'(-qn) : W'(qn);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quotient = res_reg;
endmodule
`default_nettype wire

FILE: src/phe_checker.sv
// Port-level checker for point_history_extrapolator_unit and its bind.
// Depends on phe_pkg.
`default_nettype none
module phe_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire                out_valid,
    input wire                out_ready,
    input wire phe_pkg::out_beat_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while one is in flight");
    a_zero_when_no_guess: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.can_guess |-> out_data.predicted_value == '0)
        else $error("value without a guess");
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat out of reset");
endmodule

bind point_history_extrapolator_unit phe_checker u_phe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
